FILE: rtl/core/keyed_record_table_core_assert.svh
// Assertion helpers shared by the record table modules.
`ifndef KEYED_RECORD_TABLE_CORE_ASSERT_SVH
`define KEYED_RECORD_TABLE_CORE_ASSERT_SVH

// Consequence checked in the same cycle as the trigger.
`define KRT_ASSERT_NOW(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the trigger.
`define KRT_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/krt_pkg.sv
package krt_pkg;

    // Operation codes; code 3 is a no-op
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned WORD_W = 64;

    // Command transaction
    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [KEY_W-1:0] key;
        logic [WORD_W-1:0]       name_word;
        logic [WORD_W-1:0]       group_word;
    } t_cmd;

    // Result transaction
    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] name_out;
        logic [WORD_W-1:0] group_out;
    } t_rsp;

    // Table update request
    typedef struct packed {
        logic do_insert;
        logic do_delete;
    } t_upd_ctl;

endpackage

FILE: rtl/core/krt_match.sv
module krt_match
    import krt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic signed [KEY_W-1:0] i_key,
    input  logic signed [KEY_W-1:0] i_keys   [TABLE_DEPTH],
    input  logic [WORD_W-1:0]       i_names  [TABLE_DEPTH],
    input  logic [WORD_W-1:0]       i_groups [TABLE_DEPTH],
    input  logic [CNT_W-1:0]        i_count,
    output logic [TABLE_DEPTH-1:0]  o_hit,
    output logic                    o_found,
    output logic [WORD_W-1:0]       o_name,
    output logic [WORD_W-1:0]       o_group
);

    logic [TABLE_DEPTH-1:0] match;

    // Compare the key against every occupied entry in parallel
    always_comb begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            match[j] = (CNT_W'(j) < i_count) && (i_keys[j] == i_key);
        end
    end

    // Oldest match is the lowest set bit
    assign o_hit   = match & (~match + TABLE_DEPTH'(1));
    assign o_found = |match;

    // One-hot payload select
    always_comb begin
        o_name  = '0;
        o_group = '0;
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            o_name  = o_name  | ({WORD_W{o_hit[j]}} & i_names[j]);
            o_group = o_group | ({WORD_W{o_hit[j]}} & i_groups[j]);
        end
    end

endmodule

FILE: rtl/core/krt_store.sv
module krt_store
    import krt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_upd_ctl                i_ctl,
    input  t_cmd                    i_rec,
    input  logic [TABLE_DEPTH-1:0]  i_hit,
    output logic signed [KEY_W-1:0] o_keys   [TABLE_DEPTH],
    output logic [WORD_W-1:0]       o_names  [TABLE_DEPTH],
    output logic [WORD_W-1:0]       o_groups [TABLE_DEPTH],
    output logic [CNT_W-1:0]        o_count
);

`include "keyed_record_table_core_assert.svh"

    logic signed [KEY_W-1:0] r_keys   [TABLE_DEPTH];
    logic [WORD_W-1:0]       r_names  [TABLE_DEPTH];
    logic [WORD_W-1:0]       r_groups [TABLE_DEPTH];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [TABLE_DEPTH-1:0]  shift_en;

    // Entries at or above the deleted one take their upper neighbor
    assign shift_en = ~(i_hit - TABLE_DEPTH'(1));

    // Entry count
    always_comb begin
        n_count = r_count;
        if (i_ctl.do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.do_delete) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Entry storage: append at the tail, compact on delete
    for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (i_ctl.do_insert && (r_count == CNT_W'(j))) begin
                r_keys[j]   <= i_rec.key;
                r_names[j]  <= i_rec.name_word;
                r_groups[j] <= i_rec.group_word;
            end else if (i_ctl.do_delete && shift_en[j] && (j + 1 < TABLE_DEPTH)) begin
                r_keys[j]   <= r_keys[(j + 1) % TABLE_DEPTH];
                r_names[j]  <= r_names[(j + 1) % TABLE_DEPTH];
                r_groups[j] <= r_groups[(j + 1) % TABLE_DEPTH];
            end
        end
    end

    assign o_keys   = r_keys;
    assign o_names  = r_names;
    assign o_groups = r_groups;
    assign o_count  = r_count;

    // Checks
    `KRT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(TABLE_DEPTH), "count beyond depth")
    `KRT_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, i_ctl.do_insert, r_count == $past(r_count) + CNT_W'(1), "insert did not grow table")
    `KRT_ASSERT_NOW(a_delete_hit, i_clk, i_rst_n, i_ctl.do_delete, $onehot(i_hit) && r_count != '0, "delete without single hit")

endmodule

FILE: rtl/core/keyed_record_table_core.sv
// Keyed record table: up to TABLE_DEPTH records (32-bit key, name and class
// words) kept in arrival order.
// Command channel: drive i_cmd and raise start; the transaction is taken at
// any edge where start is high and busy is low. busy never rises, so a new
// command may be issued every cycle.
// Result channel: o_valid pulses for one cycle with o_rsp; the receiver must
// take it then, there is no stall.
// Pipeline: a taken command is decoded from the command register against
// the table, and its result is taken into the result register, which
// drives o_valid (two register stages: command register, result register).
// Throughput: one command per clock. The whole table is compared in
// parallel and delete compaction shifts all later entries in the same cycle.
// Insert appends, delete removes the oldest matching key, lookup returns
// the oldest match; a full table drops inserts with a full status.
// Reset (synchronous, active low) empties the table and drops any command
// in flight; stored words are not cleared.
module keyed_record_table_core
    import krt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_rsp o_rsp
);

`include "keyed_record_table_core_assert.svh"

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    t_cmd                    r_cmd;
    logic                    r_cmd_vld;
    t_rsp                    r_rsp;
    t_rsp                    n_rsp;
    logic                    r_vld;
    t_upd_ctl                upd_ctl;
    logic signed [KEY_W-1:0] keys   [TABLE_DEPTH];
    logic [WORD_W-1:0]       names  [TABLE_DEPTH];
    logic [WORD_W-1:0]       groups [TABLE_DEPTH];
    logic [CNT_W-1:0]        count;
    logic [TABLE_DEPTH-1:0]  hit;
    logic                    found;
    logic [WORD_W-1:0]       hit_name;
    logic [WORD_W-1:0]       hit_group;
    logic                    full;

    assign busy = 1'b0;

    // Command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else begin
            r_cmd_vld <= start && !busy;
        end
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
    end

    krt_match #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CNT_W      (CNT_W)
    ) u_match (
        .i_key   (r_cmd.key),
        .i_keys  (keys),
        .i_names (names),
        .i_groups(groups),
        .i_count (count),
        .o_hit   (hit),
        .o_found (found),
        .o_name  (hit_name),
        .o_group (hit_group)
    );

    krt_store #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CNT_W      (CNT_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (upd_ctl),
        .i_rec   (r_cmd),
        .i_hit   (hit),
        .o_keys  (keys),
        .o_names (names),
        .o_groups(groups),
        .o_count (count)
    );

    assign full = (count == CNT_W'(TABLE_DEPTH));

    // Decode the command into a table update and a result
    always_comb begin
        upd_ctl   = '0;
        n_rsp     = '0;
        n_rsp.status = ST_OK;
        case (r_cmd.opcode)
            OP_INSERT: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    upd_ctl.do_insert = r_cmd_vld;
                end
            end
            OP_DELETE: begin
                if (!found) begin
                    n_rsp.status = ST_MISSING;
                end else begin
                    upd_ctl.do_delete = r_cmd_vld;
                end
            end
            OP_LOOKUP: begin
                if (!found) begin
                    n_rsp.status = ST_MISSING;
                end else begin
                    n_rsp.name_out  = hit_name;
                    n_rsp.group_out = hit_group;
                end
            end
            default: begin
                n_rsp.status = ST_OK;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r_cmd_vld;
        end
        if (r_cmd_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_vld;
    assign o_rsp   = r_rsp;

    // Checks
    `KRT_ASSERT_NOW(a_result_follows, i_clk, i_rst_n, start && !busy,
        ##2 o_valid, "accepted command gave no result")
    `KRT_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_valid && o_rsp.status != ST_OK,
        o_rsp.name_out == '0 && o_rsp.group_out == '0, "payload on failed command")
    `KRT_ASSERT_NOW(a_full_insert, i_clk, i_rst_n, o_valid && o_rsp.status == ST_FULL,
        $past(r_cmd.opcode) == OP_INSERT && $past(full), "full status without full insert")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import krt_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int BURSTS = 14;
    localparam int BURST_LEN = 50;
    localparam int CYCLE_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP = 30;

    // Shadow copy of the record table plus the answers still owed by the block
    class record_table_shadow;
        logic [KEY_W-1:0]  keys   [DEPTH];
        logic [WORD_W-1:0] names  [DEPTH];
        logic [WORD_W-1:0] groups [DEPTH];
        int fill;
        int peak_fill;
        t_rsp answers_due [$];
        int mismatches;
        int answers_seen;
        int n_insert, n_full, n_delete, n_delete_hit, n_lookup, n_found, n_nop;

        function new();
            fill = 0;
            peak_fill = 0;
            mismatches = 0;
            answers_seen = 0;
            n_insert = 0;
            n_full = 0;
            n_delete = 0;
            n_delete_hit = 0;
            n_lookup = 0;
            n_found = 0;
            n_nop = 0;
        endfunction

        // Update the table for one accepted transaction and queue its answer
        function void apply_cmd(t_cmd c);
            t_rsp r;
            int hit;
            r = '0;
            r.status = ST_OK;
            hit = -1;
            // oldest matching record wins
            for (int i = 0; i < fill; i++) begin
                if (hit < 0 && keys[i] == c.key)
                    hit = i;
            end
            case (c.opcode)
                OP_INSERT: begin
                    n_insert++;
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        keys[fill] = c.key;
                        names[fill] = c.name_word;
                        groups[fill] = c.group_word;
                        fill++;
                        if (fill > peak_fill)
                            peak_fill = fill;
                    end
                end
                OP_DELETE: begin
                    n_delete++;
                    if (hit < 0) begin
                        r.status = ST_MISSING;
                    end else begin
                        // close the gap, keeping arrival order
                        for (int i = hit; i < fill - 1; i++) begin
                            keys[i] = keys[i+1];
                            names[i] = names[i+1];
                            groups[i] = groups[i+1];
                        end
                        fill--;
                        n_delete_hit++;
                    end
                end
                OP_LOOKUP: begin
                    n_lookup++;
                    if (hit < 0) begin
                        r.status = ST_MISSING;
                    end else begin
                        r.name_out = names[hit];
                        r.group_out = groups[hit];
                        n_found++;
                    end
                end
                default: begin
                    n_nop++;
                end
            endcase
            answers_due.push_back(r);
        endfunction

        task log_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Compare one result transaction with the oldest answer owed
        task check_answer(t_rsp got);
            t_rsp want;
            answers_seen++;
            if (answers_due.size() == 0) begin
                log_mismatch($sformatf("result %0d arrived with nothing pending (status %0d)",
                                       answers_seen, got.status));
                return;
            end
            want = answers_due.pop_front();
            if (got.status !== want.status)
                log_mismatch($sformatf("result %0d status %0d, want %0d",
                                       answers_seen, got.status, want.status));
            if (got.name_out !== want.name_out)
                log_mismatch($sformatf("result %0d name %h, want %h",
                                       answers_seen, got.name_out, want.name_out));
            if (got.group_out !== want.group_out)
                log_mismatch($sformatf("result %0d class %h, want %h",
                                       answers_seen, got.group_out, want.group_out));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_cmd cmd_bus = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;
    int unsigned cycles = 0;

    record_table_shadow shadow;

    keyed_record_table_core #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd_bus),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped at cycle limit, %0d results outstanding",
                     shadow.answers_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Monitor: results first, then the transaction taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown(o_valid))
                shadow.log_mismatch("result strobe is unknown");
            else if (o_valid)
                shadow.check_answer(o_rsp);
            if (start && busy === 1'b0)
                shadow.apply_cmd(cmd_bus);
        end
    end

    // Issue one transaction, after an idle gap when gap is nonzero; returns at the falling edge after acceptance
    task automatic send_cmd(input logic [1:0] op, input logic [KEY_W-1:0] k,
                            input logic [WORD_W-1:0] nw, input logic [WORD_W-1:0] gw,
                            input int gap);
        t_cmd c;
        c.opcode = op;
        c.key = k;
        c.name_word = nw;
        c.group_word = gw;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        cmd_bus <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // Hold off the command side until every owed answer has come back
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (shadow.answers_due.size() != 0);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] pick_pool_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [KEY_W-1:0] pool [6];
        logic [KEY_W-1:0] k;
        logic [1:0] op;
        int ins_pct;
        bit no_idle;
        int gap;

        shadow = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, no-op, key and payload extremes, duplicates
        send_cmd(OP_LOOKUP, '0, '1, '1, 0);
        send_cmd(OP_DELETE, '0, '0, '0, 0);
        send_cmd(OP_NOP, 32'h1234_5678, '1, '1, 0);
        send_cmd(OP_INSERT, 32'h8000_0000, '1, '0, 0);
        send_cmd(OP_INSERT, 32'h7fff_ffff, '0, '1, 2);
        send_cmd(OP_INSERT, 32'd5, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 0);
        send_cmd(OP_INSERT, 32'd5, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 0);
        // oldest duplicate answers first, then the younger one after delete
        send_cmd(OP_LOOKUP, 32'd5, '0, '0, 0);
        send_cmd(OP_DELETE, 32'd5, '0, '0, 1);
        send_cmd(OP_LOOKUP, 32'd5, '0, '0, 0);
        // fill to capacity, then overflow
        for (int i = 0; i < DEPTH - 3; i++)
            send_cmd(OP_INSERT, 32'd100 + i, rand_word(), rand_word(), $urandom_range(0, 1));
        send_cmd(OP_INSERT, 32'd999, '1, '1, 0);
        send_cmd(OP_LOOKUP, 32'd100 + DEPTH - 4, '0, '0, 0);
        // remove the oldest record so every entry shifts
        send_cmd(OP_DELETE, 32'h8000_0000, '0, '0, 0);
        wait_drained();

        // Random bursts, each with its own insert bias, key pool and idle pattern
        for (int b = 0; b < BURSTS; b++) begin
            case ($urandom_range(0, 2))
                0: ins_pct = 80;
                1: ins_pct = 50;
                default: ins_pct = 25;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            foreach (pool[j])
                pool[j] = pick_pool_key();
            for (int n = 0; n < BURST_LEN; n++) begin
                if ($urandom_range(0, 99) < 3)
                    op = OP_NOP;
                else if ($urandom_range(0, 99) < ins_pct)
                    op = OP_INSERT;
                else if ($urandom_range(0, 1) == 0)
                    op = OP_DELETE;
                else
                    op = OP_LOOKUP;
                if ($urandom_range(0, 9) == 0)
                    k = $urandom;
                else
                    k = pool[$urandom_range(0, 5)];
                gap = no_idle ? 0 : $urandom_range(0, 6);
                send_cmd(op, k, rand_word(), rand_word(), gap);
            end
            if (b == BURSTS / 2)
                wait_drained();
        end

        // Drain and give the pipeline time to show any stray result
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts (%0d refused on a full table), %0d deletes (%0d hits),",
                 shadow.n_insert, shadow.n_full, shadow.n_delete, shadow.n_delete_hit);
        $display("%0d lookups (%0d hits), %0d no-ops; peak fill %0d of %0d; %0d results checked",
                 shadow.n_lookup, shadow.n_found, shadow.n_nop, shadow.peak_fill, DEPTH,
                 shadow.answers_seen);
        if (shadow.mismatches == 0 && shadow.answers_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
